>>> rtl/core/mdtc_pkg.sv
// ----------------------------------------------------------------------------
// Discharge time capture package
// Shared widths, reset values, register indexes and cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mdtc_pkg;

    localparam int NUM_CHANNELS_DEF = 24;
    localparam int CH_W             = 5;
    localparam int TICK_W           = 16;
    localparam int OVS_W            = 8;
    localparam int PIN_W            = 24;
    localparam int S_TDATA_W        = 24;
    localparam int M_TDATA_W        = 24;
    localparam int M_PAD_W          = M_TDATA_W - CH_W - TICK_W;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 16;

    localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [OVS_W-1:0]  OVS_RST     = 8'd1;

    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERSAMPLE = 1'd1;

    typedef struct packed {
        logic              tick;
        logic              first;
        logic              ends;
        logic              emit;
        logic              shift;
        logic [TICK_W-1:0] elapsed;
        logic [TICK_W-1:0] timeout;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/mdtc_cell.sv
// ----------------------------------------------------------------------------
// Discharge time capture cell
// Per-channel capture flag, current and maximum discharge time, and one stage
// of the result shift chain toward channel zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mdtc_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire mdtc_pkg::cell_ctrl_t        ctrl,
    input  wire logic                        pin_level,
    input  wire logic [mdtc_pkg::TICK_W-1:0] nbr_val,
    output logic                             cap_now,
    output logic [mdtc_pkg::TICK_W-1:0]      out_val
);

    logic                        captured_reg, captured_next;
    logic [mdtc_pkg::TICK_W-1:0] cur_reg, cur_next;
    logic [mdtc_pkg::TICK_W-1:0] max_reg, max_next;
    logic [mdtc_pkg::TICK_W-1:0] out_reg, out_next;
    logic                        cap_eff;
    logic                        new_cap;
    logic [mdtc_pkg::TICK_W-1:0] len_val;
    logic [mdtc_pkg::TICK_W-1:0] max_upd;

    assign cap_eff = captured_reg && !ctrl.first;
    assign new_cap = !cap_eff && !pin_level;
    assign cap_now = cap_eff || !pin_level;
    assign len_val = !cap_now ? ctrl.timeout : (new_cap ? ctrl.elapsed : cur_reg);
    assign max_upd = (len_val > max_reg) ? len_val : max_reg;

    always_comb begin
        captured_next = captured_reg;
        cur_next      = cur_reg;
        max_next      = max_reg;
        out_next      = out_reg;
        if (ctrl.tick) begin
            if (new_cap) begin
                cur_next = ctrl.elapsed;
            end
            captured_next = ctrl.ends ? 1'b0 : cap_now;
            if (ctrl.ends) begin
                max_next = ctrl.emit ? '0 : max_upd;
            end
        end
        if (ctrl.emit) begin
            out_next = max_upd;
        end else if (ctrl.shift) begin
            out_next = nbr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            captured_reg <= 1'b0;
            max_reg      <= '0;
        end else begin
            captured_reg <= captured_next;
            max_reg      <= max_next;
        end
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign out_val = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/multichannel_discharge_time_capture.sv
// ----------------------------------------------------------------------------
// Multichannel discharge time capture
// Times the first low level of each channel per reading, keeps the maximum
// over several readings and reports one result per channel.
//
// Channel   Dir   Handshake         Payload
// s_        in    tvalid/tready     tdata: pin_levels; tuser: first_tick
// m_        out   tvalid/tready     tdata: channel, pulse_ticks; tlast: last
// cfg_      in    we                addr: register index; wdata: value
//
// One tick is taken per cycle while s_tready is high; a reading is resolved
// in the cycle its closing tick is accepted, by the row of per-channel cells.
// A report loads the cell shift chain and drains NUM_CHANNELS results, one
// per cycle taken by the sink. A tick that would close a report while the
// previous one still drains waits until its last result is taken.
// Reset is synchronous and leaves every reading and maximum clear.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_discharge_time_capture #(
    parameter int NUM_CHANNELS = mdtc_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [mdtc_pkg::S_TDATA_W-1:0]  s_tdata,   // [23:0] pin_levels
    input  wire logic                            s_tuser,   // [0] first_tick
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [mdtc_pkg::M_TDATA_W-1:0]       m_tdata,   // [4:0] channel, [20:5] pulse_ticks
    output logic                                 m_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [mdtc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [mdtc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic [mdtc_pkg::TICK_W-1:0] timeout_reg, timeout_next;
    logic [mdtc_pkg::OVS_W-1:0]  ovs_reg, ovs_next;
    logic [mdtc_pkg::TICK_W-1:0] elapsed_reg, elapsed_next;
    logic                        active_reg, active_next;
    logic [mdtc_pkg::OVS_W-1:0]  rdone_reg, rdone_next;
    logic                        busy_reg, busy_next;
    logic [mdtc_pkg::CH_W-1:0]   head_reg, head_next;

    mdtc_pkg::cell_ctrl_t        ctrl;
    logic [NUM_CHANNELS-1:0]     cap_now;
    logic [mdtc_pkg::TICK_W-1:0] out_val [NUM_CHANNELS+1];

    logic                        s_fire, m_fire;
    logic                        active_eff;
    logic [mdtc_pkg::TICK_W-1:0] elapsed_eff;
    logic                        would_end, would_emit;
    logic [mdtc_pkg::OVS_W-1:0]  rdone_inc;
    logic                        last_head;

    assign s_fire      = s_tvalid && s_tready;
    assign m_fire      = m_tvalid && m_tready;
    assign active_eff  = s_tuser || active_reg;
    assign elapsed_eff = s_tuser ? '0 : elapsed_reg;
    assign rdone_inc   = rdone_reg + 1'b1;
    assign would_end   = active_eff && ((&cap_now) || (elapsed_eff >= timeout_reg));
    assign would_emit  = would_end && (rdone_inc >= ovs_reg);
    assign last_head   = (head_reg == mdtc_pkg::CH_W'(NUM_CHANNELS - 1));

    assign s_tready = !busy_reg || !would_emit || (last_head && m_tready);

    assign ctrl.tick    = s_fire && active_eff;
    assign ctrl.first   = s_tuser;
    assign ctrl.ends    = s_fire && would_end;
    assign ctrl.emit    = s_fire && would_emit;
    assign ctrl.shift   = m_fire;
    assign ctrl.elapsed = elapsed_eff;
    assign ctrl.timeout = timeout_reg;

    assign out_val[NUM_CHANNELS] = '0;

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
        logic pin;
        if (i < mdtc_pkg::PIN_W) begin : g_pin
            assign pin = s_tdata[i];
        end else begin : g_low
            assign pin = 1'b0;
        end
        mdtc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .pin_level (pin),
            .nbr_val   (out_val[i+1]),
            .cap_now   (cap_now[i]),
            .out_val   (out_val[i])
        );
    end

    always_comb begin
        timeout_next = timeout_reg;
        ovs_next     = ovs_reg;
        if (cfg_we) begin
            case (cfg_addr)
                mdtc_pkg::REG_TIMEOUT:    timeout_next = cfg_wdata;
                mdtc_pkg::REG_OVERSAMPLE: ovs_next     = cfg_wdata[mdtc_pkg::OVS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        elapsed_next = elapsed_reg;
        active_next  = active_reg;
        rdone_next   = rdone_reg;
        if (ctrl.tick) begin
            active_next  = !ctrl.ends;
            elapsed_next = ctrl.ends ? '0 : elapsed_eff + 1'b1;
        end
        if (ctrl.emit) begin
            rdone_next = '0;
        end else if (ctrl.ends) begin
            rdone_next = rdone_inc;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        head_next = head_reg;
        if (ctrl.emit) begin
            busy_next = 1'b1;
            head_next = '0;
        end else if (m_fire) begin
            if (last_head) begin
                busy_next = 1'b0;
                head_next = '0;
            end else begin
                head_next = head_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= mdtc_pkg::TIMEOUT_RST;
            ovs_reg     <= mdtc_pkg::OVS_RST;
            elapsed_reg <= '0;
            active_reg  <= 1'b0;
            rdone_reg   <= '0;
            busy_reg    <= 1'b0;
            head_reg    <= '0;
        end else begin
            timeout_reg <= timeout_next;
            ovs_reg     <= ovs_next;
            elapsed_reg <= elapsed_next;
            active_reg  <= active_next;
            rdone_reg   <= rdone_next;
            busy_reg    <= busy_next;
            head_reg    <= head_next;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {{mdtc_pkg::M_PAD_W{1'b0}}, out_val[0], head_reg};
    assign m_tlast  = last_head;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> (!busy_reg || (last_head && m_tready)))
        else $error("report loaded over an undrained one");

    a_emit_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |=> (m_tvalid && head_reg == '0))
        else $error("report does not start at channel zero");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (head_reg <= mdtc_pkg::CH_W'(NUM_CHANNELS - 1)))
        else $error("result head past last channel");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (elapsed_reg == '0))
        else $error("elapsed count held outside a reading");

endmodule

`default_nettype wire

>>> tb/multichannel_discharge_time_capture_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Discharge time capture testbench
// Drives tick streams into the capture block, tracks every reading in a
// behavioral tracker of its own and compares each per-channel pulse result
// in arrival order. Directed cases first, then randomized readings under
// several source and sink idling mixes, with one long sink hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_discharge_time_capture_tb;

    localparam int NCH           = mdtc_pkg::NUM_CHANNELS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 60;

    typedef struct {
        logic [mdtc_pkg::CH_W-1:0]   channel;
        logic [mdtc_pkg::TICK_W-1:0] pulse_ticks;
        logic                        is_last;
    } pulse_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [mdtc_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [mdtc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tlast;
    logic                            cfg_we    = 1'b0;
    logic [mdtc_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [mdtc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // tracker state
    logic [mdtc_pkg::TICK_W-1:0] trk_timeout  = mdtc_pkg::TIMEOUT_RST;
    logic [mdtc_pkg::OVS_W-1:0]  trk_ovs      = mdtc_pkg::OVS_RST;
    logic [mdtc_pkg::TICK_W-1:0] trk_elapsed  = '0;
    logic                        trk_active   = 1'b0;
    logic [mdtc_pkg::PIN_W-1:0]  trk_captured = '0;
    logic [mdtc_pkg::TICK_W-1:0] trk_cur_len [NCH];
    logic [mdtc_pkg::TICK_W-1:0] trk_max_len [NCH];
    logic [mdtc_pkg::OVS_W-1:0]  trk_readings = '0;

    pulse_result_t expected_pulses[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_starts   = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int set_timeout   = mdtc_pkg::TIMEOUT_RST;

    multichannel_discharge_time_capture dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [23:0] pin_levels
        .s_tuser   (s_tuser),   // [0] first_tick
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [4:0] channel, [20:5] pulse_ticks
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    initial begin
        for (int ch = 0; ch < NCH; ch++) begin
            trk_cur_len[ch] = '0;
            trk_max_len[ch] = '0;
        end
    end

    task automatic time_discharge(input logic [mdtc_pkg::PIN_W-1:0] pins,
                                  input logic first_tick);
        logic [mdtc_pkg::PIN_W-1:0]  full;
        logic [mdtc_pkg::TICK_W-1:0] len;
        pulse_result_t               res;
        full = '1;
        if (first_tick) begin
            trk_active   = 1'b1;
            trk_elapsed  = '0;
            trk_captured = '0;
        end
        if (!trk_active) return;
        for (int ch = 0; ch < NCH; ch++) begin
            if (!trk_captured[ch] && !pins[ch]) begin
                trk_cur_len[ch]  = trk_elapsed;
                trk_captured[ch] = 1'b1;
            end
        end
        if (trk_captured != full && trk_elapsed < trk_timeout) begin
            trk_elapsed = trk_elapsed + 1'b1;
            return;
        end
        for (int ch = 0; ch < NCH; ch++) begin
            len = trk_captured[ch] ? trk_cur_len[ch] : trk_timeout;
            trk_cur_len[ch] = len;
            if (len > trk_max_len[ch]) trk_max_len[ch] = len;
        end
        trk_active   = 1'b0;
        trk_captured = '0;
        trk_elapsed  = '0;
        trk_readings = trk_readings + 1'b1;
        if (trk_readings >= trk_ovs) begin
            for (int ch = 0; ch < NCH; ch++) begin
                res.channel     = mdtc_pkg::CH_W'(ch);
                res.pulse_ticks = trk_max_len[ch];
                res.is_last     = (ch == NCH - 1);
                expected_pulses.push_back(res);
                trk_max_len[ch] = '0;
            end
            trk_readings = '0;
        end
    endtask

    always @(posedge aclk) begin : result_check
        pulse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pulses.size() == 0) begin
                $error("unexpected result: channel %0d pulse_ticks %0d",
                       m_tdata[mdtc_pkg::CH_W-1:0],
                       m_tdata[mdtc_pkg::CH_W+mdtc_pkg::TICK_W-1:mdtc_pkg::CH_W]);
                error_count++;
            end else begin
                want = expected_pulses.pop_front();
                if (m_tdata[mdtc_pkg::CH_W-1:0] !== want.channel) begin
                    $error("channel mismatch: expected %0d, actual %0d",
                           want.channel, m_tdata[mdtc_pkg::CH_W-1:0]);
                    error_count++;
                end
                if (m_tdata[mdtc_pkg::CH_W+mdtc_pkg::TICK_W-1:mdtc_pkg::CH_W]
                        !== want.pulse_ticks) begin
                    $error("pulse_ticks mismatch: expected %0d, actual %0d",
                           want.pulse_ticks,
                           m_tdata[mdtc_pkg::CH_W+mdtc_pkg::TICK_W-1:mdtc_pkg::CH_W]);
                    error_count++;
                end
                if (m_tlast !== want.is_last) begin
                    $error("last mismatch: expected %0d, actual %0d", want.is_last, m_tlast);
                    error_count++;
                end
            end
        end
        if (aresetn && cfg_we) begin
            if (cfg_addr == mdtc_pkg::REG_TIMEOUT)
                trk_timeout = cfg_wdata[mdtc_pkg::TICK_W-1:0];
            else if (cfg_addr == mdtc_pkg::REG_OVERSAMPLE)
                trk_ovs = cfg_wdata[mdtc_pkg::OVS_W-1:0];
        end
        if (aresetn && s_tvalid && s_tready)
            time_discharge(s_tdata[mdtc_pkg::PIN_W-1:0], s_tuser);
    end

    always @(posedge aclk) begin
        if (hold_starts != hold_seen) begin
            hold_seen = hold_starts;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_tick(input logic [mdtc_pkg::PIN_W-1:0] pins, input logic first_tick);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pins;
        s_tuser  <= first_tick;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_pulses.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [mdtc_pkg::CFG_ADDR_W-1:0] idx,
                                  input logic [mdtc_pkg::CFG_DATA_W-1:0] value);
        settle_block();
        if (idx == mdtc_pkg::REG_TIMEOUT) set_timeout = value;
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // one reading: each channel discharges at a random tick, noise after capture
    task automatic run_reading(input bit truncate, inout int count);
        int                         disch [NCH];
        int                         span;
        int                         max_d;
        int                         t_end;
        logic [mdtc_pkg::PIN_W-1:0] pins;
        span  = (set_timeout > 30) ? 30 : set_timeout + 2;
        max_d = 0;
        for (int ch = 0; ch < NCH; ch++) begin
            disch[ch] = $urandom_range(span, 0);
            if (disch[ch] > max_d) max_d = disch[ch];
        end
        t_end = (max_d < set_timeout) ? max_d : set_timeout;
        if (truncate) t_end = $urandom_range(t_end, 0);
        for (int t = 0; t <= t_end; t++) begin
            for (int ch = 0; ch < NCH; ch++)
                pins[ch] = (t < disch[ch]) ? 1'b1 : 1'($urandom_range(1, 0));
            send_tick(pins, t == 0);
            count++;
        end
    endtask

    task automatic pick_settings();
        int r;
        logic [mdtc_pkg::TICK_W-1:0] tmo;
        logic [mdtc_pkg::OVS_W-1:0]  ovs;
        r = $urandom_range(99, 0);
        if (r < 8)       tmo = 16'd0;
        else if (r < 16) tmo = 16'hFFFF;
        else if (r < 40) tmo = mdtc_pkg::TICK_W'($urandom_range(3, 1));
        else             tmo = mdtc_pkg::TICK_W'($urandom_range(24, 4));
        r = $urandom_range(99, 0);
        ovs = (r < 10) ? 8'd0 : mdtc_pkg::OVS_W'($urandom_range(3, 1));
        write_register(mdtc_pkg::REG_TIMEOUT, tmo);
        write_register(mdtc_pkg::REG_OVERSAMPLE, {8'($urandom_range(255, 0)), ovs});
    endtask

    task automatic test_default_settings();
        src_idle_pct   = 29;
        sink_stall_pct = 29;
        send_tick(24'h5A5A5A, 1'b0);
        send_tick(24'hA5A5A5, 1'b0);
        send_tick(24'hFFFFFF, 1'b1);
        send_tick(24'hF0F0F0, 1'b0);
        send_tick(24'h000000, 1'b0);
        settle_block();
    endtask

    task automatic test_timeout_extremes();
        write_register(mdtc_pkg::REG_TIMEOUT, 16'd0);
        send_tick(24'hFFFFFF, 1'b1);
        send_tick(24'h3C3C3C, 1'b1);
        write_register(mdtc_pkg::REG_TIMEOUT, 16'd1);
        send_tick(24'hFFFFFF, 1'b1);
        send_tick(24'hFFFFFF, 1'b0);
        write_register(mdtc_pkg::REG_TIMEOUT, 16'hFFFF);
        send_tick(24'h800001, 1'b1);
        send_tick(24'h000000, 1'b0);
        settle_block();
    endtask

    task automatic test_restart();
        write_register(mdtc_pkg::REG_TIMEOUT, 16'd10);
        send_tick(24'hFFFFFF, 1'b1);
        send_tick(24'h0F0F0F, 1'b0);
        send_tick(24'hFFFF00, 1'b1);
        send_tick(24'h000000, 1'b0);
        settle_block();
    endtask

    task automatic test_timeout_lowered();
        write_register(mdtc_pkg::REG_TIMEOUT, 16'd50);
        send_tick(24'hFFFFFF, 1'b1);
        send_tick(24'h7FFFFF, 1'b0);
        send_tick(24'h7FFFFE, 1'b0);
        send_tick(24'hFFFFFF, 1'b0);
        send_tick(24'h00FFFF, 1'b0);
        write_register(mdtc_pkg::REG_TIMEOUT, 16'd3);
        send_tick(24'hFFFFFF, 1'b0);
        settle_block();
    endtask

    task automatic test_oversample();
        write_register(mdtc_pkg::REG_OVERSAMPLE, 16'd0);
        send_tick(24'h123456, 1'b1);
        send_tick(24'h000000, 1'b0);
        write_register(mdtc_pkg::REG_OVERSAMPLE, 16'd2);
        send_tick(24'hFFFFFF, 1'b1);
        send_tick(24'h000000, 1'b0);
        send_tick(24'h000000, 1'b1);
        write_register(mdtc_pkg::REG_OVERSAMPLE, 16'd255);
        send_tick(24'hAAAAAA, 1'b1);
        send_tick(24'h000000, 1'b0);
        send_tick(24'h555555, 1'b1);
        send_tick(24'h000000, 1'b0);
        // lower below the readings already taken
        write_register(mdtc_pkg::REG_OVERSAMPLE, 16'd1);
        send_tick(24'h000000, 1'b1);
        settle_block();
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_register(mdtc_pkg::REG_TIMEOUT, 16'd5);
        write_register(mdtc_pkg::REG_OVERSAMPLE, 16'd1);
        hold_starts++;
        for (int i = 0; i < 30; i++)
            send_tick(24'($urandom_range(24'hFFFFFF, 0)) & 24'h0F0F0F, (i % 6) == 0);
        settle_block();
    endtask

    task automatic test_random_readings(input int idle_pct, input int stall_pct);
        int count;
        int readings;
        int r;
        count    = 0;
        readings = 0;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        pick_settings();
        while (count < PHASE_ITEMS) begin
            r = $urandom_range(99, 0);
            if (r < 70) begin
                run_reading(1'b0, count);
            end else if (r < 80) begin
                run_reading(1'b1, count);
            end else if (r < 90) begin
                repeat ($urandom_range(3, 1)) send_tick(24'($urandom_range(24'hFFFFFF, 0)), 1'b0);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    send_tick(24'($urandom_range(24'hFFFFFF, 0)), $urandom_range(3, 0) == 0);
                    count++;
                end
            end
            readings++;
            if (readings % 12 == 0) pick_settings();
        end
        settle_block();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_settings();
        test_timeout_extremes();
        test_restart();
        test_timeout_lowered();
        test_oversample();
        test_backpressure();
        test_random_readings(0, 0);
        test_random_readings(57, 0);
        test_random_readings(0, 57);
        test_random_readings(29, 29);
        settle_block();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
